// ----- design/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants for the HSV to RGBA8 converter: hue sector codes, the
// alpha byte and the reciprocal used for the divide-by-255 step.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    typedef logic [2:0] sector_t;

    localparam sector_t SECTOR_RED_YELLOW    = 3'd0;
    localparam sector_t SECTOR_YELLOW_GREEN  = 3'd1;
    localparam sector_t SECTOR_GREEN_CYAN    = 3'd2;
    localparam sector_t SECTOR_CYAN_BLUE     = 3'd3;
    localparam sector_t SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam sector_t SECTOR_MAGENTA_RED   = 3'd5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // ceil(2^24 / 255); floor(y * RECIP_255 / 2^24) equals floor(y / 255)
    // for every y below 66052.
    localparam logic [16:0] RECIP_255   = 17'h10102;
    localparam int          RECIP_SHIFT = 24;

endpackage

// ----- design/hsvrgb_div255.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_div255
// Exact floor(y / 255) for a 16-bit dividend, done as one multiplication by
// a fixed-point reciprocal. The quotient always fits in a byte here.
// ----------------------------------------------------------------------------
module hsvrgb_div255
(
    input  logic [15:0] y,
    output logic [7:0]  quo
);

    logic [32:0] prod;

    assign prod = 33'(y) * 33'(hsvrgb_pkg::RECIP_255);
    assign quo  = prod[hsvrgb_pkg::RECIP_SHIFT +: 8];

endmodule

// ----- design/hsv_to_rgba8_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgba8_converter
// Pipelined HSV to packed RGBA8 color conversion.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at a rising edge where start is high and busy is low.
//   busy is held low, so a new word may enter on every clock.
//   hue is an unsigned fraction of a full turn; only its low HUE_BITS bits
//   count. saturation and brightness are bytes where 255 means 1.0.
//   Each result appears on rgba for exactly one cycle with done high,
//   once the word has passed the register stages in order: one stage scales hue by six,
//   then the saturation products, the brightness products, the rounding
//   offset, and finally the divide by 255 and sector select each take one
//   register stage. Throughput is one word per clock.
//   rgba holds red in bits 7:0, green in 15:8, blue in 23:16 and alpha,
//   always 255, in 31:24.
//   Reset clears all valid bits, so no done pulse follows reset until a
//   word is taken. The receiver cannot hold results off, and the pipeline
//   never stalls.
// ----------------------------------------------------------------------------
module hsv_to_rgba8_converter
#(
    parameter int HUE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        done,
    output logic [31:0] rgba
);

    localparam int HB = HUE_BITS;
    localparam logic [HB:0]    ONE      = (HB + 1)'(1) << HB;
    localparam logic [HB+7:0]  FULL     = (HB + 8)'(255) << HB;
    localparam logic [HB+15:0] ROUND_Q  = (HB + 16)'(255) << (HB - 1);
    localparam logic [15:0]    ROUND_P  = 16'd127;

    logic accept;
    logic [HB-1:0] hue_w;
    logic [HB+2:0] h6;

    // Valid bits for the five register stages.
    logic [4:0] vld_reg, vld_next;

    // Stage 1: sector and fraction.
    hsvrgb_pkg::sector_t sector1_reg;
    logic [HB-1:0]       f1_reg;
    logic [7:0]          s1_reg, v1_reg;

    // Stage 2: saturation products.
    hsvrgb_pkg::sector_t sector2_reg;
    logic [HB+7:0]       sf2_reg, sg2_reg;
    logic [15:0]         np2_reg;
    logic [7:0]          v2_reg;
    logic [HB:0]         one_minus_f;
    logic [HB+8:0]       sg_full;

    // Stage 3: brightness products.
    hsvrgb_pkg::sector_t sector3_reg;
    logic [HB+15:0]      mq3_reg, mt3_reg;
    logic [15:0]         yp3_reg;
    logic [7:0]          v3_reg;

    // Stage 4: rounded dividends for the divide by 255.
    hsvrgb_pkg::sector_t sector4_reg;
    logic [15:0]         yq4_reg, yt4_reg, yp4_reg;
    logic [7:0]          v4_reg;
    logic [HB+15:0]      sum_q, sum_t;

    // Output stage.
    logic [7:0]  p_byte, q_byte, t_byte;
    logic [7:0]  red, green, blue;
    logic [31:0] rgba_reg, rgba_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign hue_w = HB'(hue);
    assign h6    = (HB + 3)'(hue_w) * (HB + 3)'(6);

    assign one_minus_f = ONE - (HB + 1)'(f1_reg);
    assign sg_full     = (HB + 9)'(s1_reg) * (HB + 9)'(one_minus_f);

    assign sum_q = mq3_reg + ROUND_Q;
    assign sum_t = mt3_reg + ROUND_Q;

    assign vld_next = {vld_reg[3:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sector1_reg <= hsvrgb_pkg::sector_t'(h6[HB+2:HB]);
        f1_reg      <= h6[HB-1:0];
        s1_reg      <= saturation;
        v1_reg      <= brightness;

        sector2_reg <= sector1_reg;
        sf2_reg     <= (HB + 8)'(s1_reg) * (HB + 8)'(f1_reg);
        sg2_reg     <= sg_full[HB+7:0];
        np2_reg     <= 16'(v1_reg) * 16'(8'd255 - s1_reg);
        v2_reg      <= v1_reg;

        sector3_reg <= sector2_reg;
        mq3_reg     <= (HB + 16)'(v2_reg) * (HB + 16)'(FULL - sf2_reg);
        mt3_reg     <= (HB + 16)'(v2_reg) * (HB + 16)'(FULL - sg2_reg);
        yp3_reg     <= np2_reg + ROUND_P;
        v3_reg      <= v2_reg;

        sector4_reg <= sector3_reg;
        yq4_reg     <= sum_q[HB+15:HB];
        yt4_reg     <= sum_t[HB+15:HB];
        yp4_reg     <= yp3_reg;
        v4_reg      <= v3_reg;

        rgba_reg    <= rgba_next;
    end

    hsvrgb_div255 u_div_p
    (
        .y   (yp4_reg),
        .quo (p_byte)
    );

    hsvrgb_div255 u_div_q
    (
        .y   (yq4_reg),
        .quo (q_byte)
    );

    hsvrgb_div255 u_div_t
    (
        .y   (yt4_reg),
        .quo (t_byte)
    );

    always_comb
    begin
        unique case (sector4_reg)
            hsvrgb_pkg::SECTOR_RED_YELLOW:
            begin
                red = v4_reg; green = t_byte; blue = p_byte;
            end
            hsvrgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                red = q_byte; green = v4_reg; blue = p_byte;
            end
            hsvrgb_pkg::SECTOR_GREEN_CYAN:
            begin
                red = p_byte; green = v4_reg; blue = t_byte;
            end
            hsvrgb_pkg::SECTOR_CYAN_BLUE:
            begin
                red = p_byte; green = q_byte; blue = v4_reg;
            end
            hsvrgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                red = t_byte; green = p_byte; blue = v4_reg;
            end
            default:
            begin
                red = v4_reg; green = p_byte; blue = q_byte;
            end
        endcase
        rgba_next = {hsvrgb_pkg::ALPHA_OPAQUE, blue, green, red};
    end

    assign done = vld_reg[4];
    assign rgba = rgba_reg;

endmodule

// ----- design/hsvrgb_checker.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks for the HSV to RGBA8 converter: fixed latency, no
// spurious results, opaque alpha and grey output at zero saturation.
// ----------------------------------------------------------------------------
module hsvrgb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [7:0]  saturation,
    input logic [7:0]  brightness,
    input logic        done,
    input logic [31:0] rgba
);

    localparam int LATENCY = 5;

    // Every accepted word yields its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after accepted word");

    // A result only ever follows an accepted word.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted word");

    // Alpha is always opaque.
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rgba[31:24] == hsvrgb_pkg::ALPHA_OPAQUE))
        else $error("alpha byte is not opaque");

    // Zero saturation gives grey at the input brightness.
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(saturation == 8'd0, LATENCY))
        |-> ((rgba[7:0] == $past(brightness, LATENCY))
             && (rgba[15:8] == rgba[7:0]) && (rgba[23:16] == rgba[7:0])))
        else $error("zero saturation did not give grey");

endmodule

bind hsv_to_rgba8_converter hsvrgb_checker u_hsvrgb_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .rgba       (rgba)
);
